FILE: rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps

package i2cbm_pkg;

   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DELAY_W  = 9;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [OPCODE_W-1:0] OP_START     = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_STOP      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_WRITE     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_ACK  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ_NACK = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PHASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PHASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_LIMIT   = 2'd2;

   localparam logic [BYTE_W-1:0] LONG_PHASE_RESET  = 8'd50;
   localparam logic [BYTE_W-1:0] SHORT_PHASE_RESET = 8'd25;
   localparam logic [BYTE_W-1:0] ACK_LIMIT_RESET   = 8'd201;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic                command_valid;
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   write_byte;
      logic                sda_sample;
   } req_word_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_release;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_byte;
      logic              ack_seen;
   } rsp_word_type;

   typedef struct packed {
      logic                 enable;
      logic [CSR_IDX_W-1:0] index;
      logic [BYTE_W-1:0]    data;
   } csr_write_type;

endpackage

FILE: rtl/i2c_bit_level_master.sv
`timescale 1ns / 1ps

// i2c bit-level master: each word on the req_ side is one tick of bus timing (sampled sda
// and an optional command) and yields exactly one rsp_ word with the scl/sda levels and
// status for that tick. one word is taken every cycle while req_stall is low; a word goes
// through an input register, one pass of the segment sequencer and a result register that
// drives the rsp_ ports. the result register lets the next word enter while a finished one
// waits; req_stall rises only when both registers are full and rsp_stall is high.
// configuration writes are taken at any time but belong to idle periods.

module i2c_bit_level_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command_valid,
   input  logic [i2cbm_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [i2cbm_pkg::BYTE_W-1:0]     req_write_byte,
   input  logic                               req_sda_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_scl_level,
   output logic                               rsp_sda_release,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [i2cbm_pkg::BYTE_W-1:0]     rsp_read_byte,
   output logic                               rsp_ack_seen,
   input  logic                               csr_write_enable,
   input  logic [i2cbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cbm_pkg::BYTE_W-1:0]     csr_write_data
);

   logic                       in_valid_ff, in_valid_in;
   i2cbm_pkg::req_word_type  in_word_ff;
   logic                       out_valid_ff, out_valid_in;
   i2cbm_pkg::rsp_word_type  out_word_ff;
   i2cbm_pkg::rsp_word_type  step_word;
   i2cbm_pkg::csr_write_type csr_write;
   logic                       out_ready;
   logic                       req_accept;
   logic                       step_en;

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;
   assign step_en    = in_valid_ff && out_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !out_ready);
   assign out_valid_in = step_en || (out_valid_ff && rsp_stall);

   assign csr_write.enable = csr_write_enable;
   assign csr_write.index  = csr_index;
   assign csr_write.data   = csr_write_data;

   i2cbm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .req_word  (in_word_ff),
      .csr_write (csr_write),
      .rsp_word  (step_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         in_word_ff.command_valid <= req_command_valid;
         in_word_ff.opcode        <= req_opcode;
         in_word_ff.write_byte    <= req_write_byte;
         in_word_ff.sda_sample    <= req_sda_sample;
      end
      if (step_en) begin
         out_word_ff <= step_word;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_level   = out_word_ff.scl_level;
   assign rsp_sda_release = out_word_ff.sda_release;
   assign rsp_busy_res    = out_word_ff.busy_res;
   assign rsp_done_res    = out_word_ff.done_res;
   assign rsp_read_byte   = out_word_ff.read_byte;
   assign rsp_ack_seen    = out_word_ff.ack_seen;

endmodule

FILE: rtl/i2cbm_core.sv
`timescale 1ns / 1ps

module i2cbm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  i2cbm_pkg::req_word_type  req_word,
   input  i2cbm_pkg::csr_write_type csr_write,
   output i2cbm_pkg::rsp_word_type  rsp_word
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_WH, PH_WL,
      PH_AREL, PH_AHI, PH_APOLL, PH_ALO, PH_RH, PH_RL, PH_RAH, PH_RAL
   } phase_type;

   logic [i2cbm_pkg::BYTE_W-1:0]   long_phase_ff, short_phase_ff, ack_limit_ff;

   phase_type                        phase_ff, phase_in;
   logic [i2cbm_pkg::OPCODE_W-1:0] active_op_ff, active_op_in;
   logic [3:0]                       bit_index_ff, bit_index_in;
   logic [i2cbm_pkg::DELAY_W-1:0]  delay_ff, delay_in;
   logic [i2cbm_pkg::BYTE_W-1:0]   ack_wait_ff, ack_wait_in;
   logic [i2cbm_pkg::BYTE_W-1:0]   shift_ff, shift_in;
   logic                             scl_ff, scl_in;
   logic                             sda_ff, sda_in;
   logic                             ack_flag_ff, ack_flag_in;
   logic [i2cbm_pkg::BYTE_W-1:0]   read_result_ff, read_result_in;
   logic                             done_in;

   logic [i2cbm_pkg::DELAY_W-1:0]  long_d, long2_d, short_d;
   logic [i2cbm_pkg::BYTE_W-1:0]   shifted;
   logic [3:0]                       bit_next;

   assign long_d   = {1'b0, long_phase_ff};
   assign long2_d  = {long_phase_ff, 1'b0};
   assign short_d  = {1'b0, short_phase_ff};
   assign shifted  = {shift_ff[i2cbm_pkg::BYTE_W-2:0], 1'b0};
   assign bit_next = bit_index_ff + 4'd1;

   always_comb begin
      phase_in       = phase_ff;
      active_op_in   = active_op_ff;
      bit_index_in   = bit_index_ff;
      delay_in       = delay_ff;
      ack_wait_in    = ack_wait_ff;
      shift_in       = shift_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      ack_flag_in    = ack_flag_ff;
      read_result_in = read_result_ff;
      done_in        = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (req_word.command_valid && (req_word.opcode <= i2cbm_pkg::OP_READ_NACK)) begin
            active_op_in = req_word.opcode;
            bit_index_in = 4'd0;
            scl_in       = 1'b1;
            unique case (req_word.opcode)
               i2cbm_pkg::OP_START: begin
                  phase_in = PH_ST1;
                  sda_in   = 1'b1;
                  delay_in = long2_d;
               end
               i2cbm_pkg::OP_STOP: begin
                  phase_in = PH_SP1;
                  sda_in   = 1'b0;
                  delay_in = long_d;
               end
               i2cbm_pkg::OP_WRITE: begin
                  shift_in = req_word.write_byte;
                  phase_in = PH_WH;
                  sda_in   = req_word.write_byte[i2cbm_pkg::BYTE_W-1];
                  delay_in = long_d;
               end
               default: begin
                  shift_in = '0;
                  phase_in = PH_RH;
                  sda_in   = 1'b1;
                  delay_in = long_d;
               end
            endcase
         end
      end else if (phase_ff == PH_APOLL) begin
         if (!req_word.sda_sample || (ack_wait_ff >= ack_limit_ff)) begin
            ack_flag_in = !req_word.sda_sample;
            phase_in    = PH_ALO;
            scl_in      = 1'b0;
            sda_in      = 1'b1;
            delay_in    = long_d;
         end else begin
            ack_wait_in = ack_wait_ff + 8'd1;
         end
      end else if (delay_ff > 9'd1) begin
         delay_in = delay_ff - 9'd1;
      end else begin
         unique case (phase_ff)
            PH_ST1: begin
               phase_in = PH_ST2; scl_in = 1'b1; sda_in = 1'b0; delay_in = long_d;
            end
            PH_ST2: begin
               phase_in = PH_ST3; scl_in = 1'b0; sda_in = 1'b0; delay_in = long_d;
            end
            PH_SP1: begin
               phase_in = PH_SP2; scl_in = 1'b1; sda_in = 1'b1; delay_in = long2_d;
            end
            PH_WH: begin
               phase_in = PH_WL; scl_in = 1'b0; delay_in = short_d;
            end
            PH_WL: begin
               shift_in     = shifted;
               bit_index_in = bit_next;
               if (bit_next < i2cbm_pkg::BITS_PER_BYTE) begin
                  phase_in = PH_WH; scl_in = 1'b1;
                  sda_in   = shifted[i2cbm_pkg::BYTE_W-1];
                  delay_in = long_d;
               end else begin
                  phase_in = PH_AREL; scl_in = 1'b0; sda_in = 1'b1; delay_in = long2_d;
               end
            end
            PH_AREL: begin
               phase_in = PH_AHI; scl_in = 1'b1; sda_in = 1'b1; delay_in = long_d;
            end
            PH_AHI: begin
               phase_in    = PH_APOLL; scl_in = 1'b1; sda_in = 1'b1; delay_in = '0;
               ack_wait_in = '0;
            end
            PH_RH: begin
               shift_in = {shift_ff[i2cbm_pkg::BYTE_W-2:0], req_word.sda_sample};
               phase_in = PH_RL; scl_in = 1'b0; sda_in = 1'b1; delay_in = short_d;
            end
            PH_RL: begin
               bit_index_in = bit_next;
               if (bit_next < i2cbm_pkg::BITS_PER_BYTE) begin
                  phase_in = PH_RH; scl_in = 1'b1; sda_in = 1'b1; delay_in = long_d;
               end else begin
                  read_result_in = shift_ff;
                  phase_in = PH_RAH; scl_in = 1'b1;
                  sda_in   = (active_op_ff == i2cbm_pkg::OP_READ_NACK);
                  delay_in = long_d;
               end
            end
            PH_RAH: begin
               phase_in = PH_RAL; scl_in = 1'b0; sda_in = 1'b1; delay_in = short_d;
            end
            default: begin
               phase_in = PH_IDLE;
               delay_in = '0;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_phase_ff  <= i2cbm_pkg::LONG_PHASE_RESET;
         short_phase_ff <= i2cbm_pkg::SHORT_PHASE_RESET;
         ack_limit_ff   <= i2cbm_pkg::ACK_LIMIT_RESET;
         phase_ff       <= PH_IDLE;
         active_op_ff   <= '0;
         bit_index_ff   <= '0;
         delay_ff       <= '0;
         ack_wait_ff    <= '0;
         shift_ff       <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_flag_ff    <= 1'b0;
         read_result_ff <= '0;
      end else begin
         if (csr_write.enable) begin
            unique case (csr_write.index)
               i2cbm_pkg::CSR_LONG_PHASE:  long_phase_ff  <= csr_write.data;
               i2cbm_pkg::CSR_SHORT_PHASE: short_phase_ff <= csr_write.data;
               i2cbm_pkg::CSR_ACK_LIMIT:   ack_limit_ff   <= csr_write.data;
               default: ;
            endcase
         end
         if (step_en) begin
            phase_ff       <= phase_in;
            active_op_ff   <= active_op_in;
            bit_index_ff   <= bit_index_in;
            delay_ff       <= delay_in;
            ack_wait_ff    <= ack_wait_in;
            shift_ff       <= shift_in;
            scl_ff         <= scl_in;
            sda_ff         <= sda_in;
            ack_flag_ff    <= ack_flag_in;
            read_result_ff <= read_result_in;
         end
      end
   end

   assign rsp_word.scl_level   = scl_in;
   assign rsp_word.sda_release = sda_in;
   assign rsp_word.busy_res    = (phase_in != PH_IDLE);
   assign rsp_word.done_res    = done_in;
   assign rsp_word.read_byte   = read_result_in;
   assign rsp_word.ack_seen    = ack_flag_in;

endmodule

FILE: rtl/i2cbm_checker.sv
`timescale 1ns / 1ps

module i2cbm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_scl_level,
   input logic                           rsp_sda_release,
   input logic                           rsp_busy_res,
   input logic                           rsp_done_res,
   input logic [i2cbm_pkg::BYTE_W-1:0] rsp_read_byte,
   input logic                           rsp_ack_seen
);

   logic rsp_accept;
   logic last_busy_ff;
   logic last_done_ff;

   assign rsp_accept = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_busy_ff <= 1'b0;
         last_done_ff <= 1'b0;
      end else if (rsp_accept) begin
         last_busy_ff <= rsp_busy_res;
         last_done_ff <= rsp_done_res;
      end
   end

   // held word stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_scl_level) && $stable(rsp_sda_release)
         && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_byte) && $stable(rsp_ack_seen))
      else $error("rsp payload changed while stalled");

   // done only ends a command and is never busy at the same time
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_done_res |-> last_busy_ff && !rsp_busy_res)
      else $error("done without a command in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && last_done_ff |-> !rsp_done_res)
      else $error("done lasted more than one word");

   // every command opens with scl high
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !last_busy_ff && rsp_busy_res |-> rsp_scl_level)
      else $error("command started with scl low");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_scl_level   (rsp_scl_level),
   .rsp_sda_release (rsp_sda_release),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_done_res    (rsp_done_res),
   .rsp_read_byte   (rsp_read_byte),
   .rsp_ack_seen    (rsp_ack_seen)
);

FILE: bench/i2cbm_bus_checker.sv
`timescale 1ns / 1ps

module i2cbm_bus_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command_valid,
   input  logic [i2cbm_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [i2cbm_pkg::BYTE_W-1:0]    req_write_byte,
   input  logic                            req_sda_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_scl_level,
   input  logic                            rsp_sda_release,
   input  logic                            rsp_busy_res,
   input  logic                            rsp_done_res,
   input  logic [i2cbm_pkg::BYTE_W-1:0]    rsp_read_byte,
   input  logic                            rsp_ack_seen,
   input  logic                            csr_write_enable,
   input  logic [i2cbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [i2cbm_pkg::BYTE_W-1:0]    csr_write_data,
   output int                              failures,
   output int                              pending,
   output logic                            bus_idle,
   output int                              checked_words,
   output int                              finished_cmds
);

   typedef logic [i2cbm_pkg::BYTE_W-1:0] byte_type;

   typedef enum logic [3:0] {
      SEG_IDLE,
      SEG_START_HOLD,
      SEG_START_FALL,
      SEG_START_LOW,
      SEG_STOP_LOW,
      SEG_STOP_RISE,
      SEG_WR_HIGH,
      SEG_WR_LOW,
      SEG_ACK_RELEASE,
      SEG_ACK_HIGH,
      SEG_ACK_POLL,
      SEG_ACK_LOW,
      SEG_RD_HIGH,
      SEG_RD_LOW,
      SEG_RDACK_HIGH,
      SEG_RDACK_LOW
   } seg_type;

   byte_type                          long_ticks;
   byte_type                          short_ticks;
   byte_type                          ack_limit;

   seg_type                           seg;
   logic [i2cbm_pkg::OPCODE_W-1:0]    cur_op;
   logic [3:0]                        bit_count;
   logic [i2cbm_pkg::DELAY_W-1:0]     delay_left;
   byte_type                          poll_count;
   byte_type                          shifter;
   logic                              scl_q;
   logic                              sda_q;
   logic                              ack_q;
   byte_type                          read_q;
   logic                              done_q;

   i2cbm_pkg::rsp_word_type           predicted_ticks[$];
   i2cbm_pkg::rsp_word_type           exp_word;
   i2cbm_pkg::rsp_word_type           next_word;
   i2cbm_pkg::req_word_type           in_word;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns, word %0d: %s", $time, checked_words, msg);
      failures++;
   endtask

   task automatic check_field(input string field_name, input byte_type got,
                              input byte_type want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", field_name, got, want));
      end
   endtask

   task automatic enter_seg(input seg_type s, input logic scl, input logic sda,
                            input logic [i2cbm_pkg::DELAY_W-1:0] dur);
      seg        = s;
      scl_q      = scl;
      sda_q      = sda;
      delay_left = dur;
   endtask

   task automatic advance_seg(input logic sda_in);
      case (seg)
         SEG_START_HOLD: enter_seg(SEG_START_FALL, 1'b1, 1'b0, {1'b0, long_ticks});
         SEG_START_FALL: enter_seg(SEG_START_LOW, 1'b0, 1'b0, {1'b0, long_ticks});
         SEG_STOP_LOW:   enter_seg(SEG_STOP_RISE, 1'b1, 1'b1, {long_ticks, 1'b0});
         SEG_WR_HIGH:    enter_seg(SEG_WR_LOW, 1'b0, sda_q, {1'b0, short_ticks});
         SEG_WR_LOW: begin
            shifter   = shifter << 1;
            bit_count = bit_count + 4'd1;
            if (bit_count < i2cbm_pkg::BITS_PER_BYTE) begin
               enter_seg(SEG_WR_HIGH, 1'b1, shifter[i2cbm_pkg::BYTE_W-1],
                         {1'b0, long_ticks});
            end else begin
               enter_seg(SEG_ACK_RELEASE, 1'b0, 1'b1, {long_ticks, 1'b0});
            end
         end
         SEG_ACK_RELEASE: enter_seg(SEG_ACK_HIGH, 1'b1, 1'b1, {1'b0, long_ticks});
         SEG_ACK_HIGH: begin
            enter_seg(SEG_ACK_POLL, 1'b1, 1'b1, '0);
            poll_count = '0;
         end
         SEG_RD_HIGH: begin
            shifter = {shifter[i2cbm_pkg::BYTE_W-2:0], sda_in};
            enter_seg(SEG_RD_LOW, 1'b0, 1'b1, {1'b0, short_ticks});
         end
         SEG_RD_LOW: begin
            bit_count = bit_count + 4'd1;
            if (bit_count < i2cbm_pkg::BITS_PER_BYTE) begin
               enter_seg(SEG_RD_HIGH, 1'b1, 1'b1, {1'b0, long_ticks});
            end else begin
               read_q = shifter;
               enter_seg(SEG_RDACK_HIGH, 1'b1, cur_op == i2cbm_pkg::OP_READ_NACK,
                         {1'b0, long_ticks});
            end
         end
         SEG_RDACK_HIGH: enter_seg(SEG_RDACK_LOW, 1'b0, 1'b1, {1'b0, short_ticks});
         default: begin
            seg        = SEG_IDLE;
            delay_left = '0;
            done_q     = 1'b1;
         end
      endcase
   endtask

   task automatic tick_bus(input i2cbm_pkg::req_word_type w,
                           output i2cbm_pkg::rsp_word_type r);
      done_q = 1'b0;
      if (seg == SEG_IDLE) begin
         if (w.command_valid && w.opcode <= i2cbm_pkg::OP_READ_NACK) begin
            cur_op    = w.opcode;
            bit_count = '0;
            case (w.opcode)
               i2cbm_pkg::OP_START:
                  enter_seg(SEG_START_HOLD, 1'b1, 1'b1, {long_ticks, 1'b0});
               i2cbm_pkg::OP_STOP:
                  enter_seg(SEG_STOP_LOW, 1'b1, 1'b0, {1'b0, long_ticks});
               i2cbm_pkg::OP_WRITE: begin
                  shifter = w.write_byte;
                  enter_seg(SEG_WR_HIGH, 1'b1, shifter[i2cbm_pkg::BYTE_W-1],
                            {1'b0, long_ticks});
               end
               default: begin
                  shifter = '0;
                  enter_seg(SEG_RD_HIGH, 1'b1, 1'b1, {1'b0, long_ticks});
               end
            endcase
         end
      end else if (seg == SEG_ACK_POLL) begin
         if (!w.sda_sample) begin
            ack_q = 1'b1;
            enter_seg(SEG_ACK_LOW, 1'b0, 1'b1, {1'b0, long_ticks});
         end else if (poll_count >= ack_limit) begin
            ack_q = 1'b0;
            enter_seg(SEG_ACK_LOW, 1'b0, 1'b1, {1'b0, long_ticks});
         end else begin
            poll_count = poll_count + 8'd1;
         end
      end else if (delay_left > 1) begin
         delay_left = delay_left - 1'b1;
      end else begin
         advance_seg(w.sda_sample);
      end
      r.scl_level   = scl_q;
      r.sda_release = sda_q;
      r.busy_res    = seg != SEG_IDLE;
      r.done_res    = done_q;
      r.read_byte   = read_q;
      r.ack_seen    = ack_q;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         long_ticks    = i2cbm_pkg::LONG_PHASE_RESET;
         short_ticks   = i2cbm_pkg::SHORT_PHASE_RESET;
         ack_limit     = i2cbm_pkg::ACK_LIMIT_RESET;
         seg           = SEG_IDLE;
         cur_op        = '0;
         bit_count     = '0;
         delay_left    = '0;
         poll_count    = '0;
         shifter       = '0;
         scl_q         = 1'b1;
         sda_q         = 1'b1;
         ack_q         = 1'b0;
         read_q        = '0;
         done_q        = 1'b0;
         failures      = 0;
         checked_words = 0;
         finished_cmds = 0;
         predicted_ticks.delete();
         pending  <= 0;
         bus_idle <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               i2cbm_pkg::CSR_LONG_PHASE:  long_ticks  = csr_write_data;
               i2cbm_pkg::CSR_SHORT_PHASE: short_ticks = csr_write_data;
               i2cbm_pkg::CSR_ACK_LIMIT:   ack_limit   = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_ticks.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               exp_word = predicted_ticks.pop_front();
               check_field("scl_level", byte_type'(rsp_scl_level),
                           byte_type'(exp_word.scl_level));
               check_field("sda_release", byte_type'(rsp_sda_release),
                           byte_type'(exp_word.sda_release));
               check_field("busy_res", byte_type'(rsp_busy_res),
                           byte_type'(exp_word.busy_res));
               check_field("done_res", byte_type'(rsp_done_res),
                           byte_type'(exp_word.done_res));
               check_field("read_byte", rsp_read_byte, exp_word.read_byte);
               check_field("ack_seen", byte_type'(rsp_ack_seen),
                           byte_type'(exp_word.ack_seen));
               checked_words++;
            end
         end
         if (req_valid && !req_stall) begin
            in_word.command_valid = req_command_valid;
            in_word.opcode        = req_opcode;
            in_word.write_byte    = req_write_byte;
            in_word.sda_sample    = req_sda_sample;
            tick_bus(in_word, next_word);
            predicted_ticks.push_back(next_word);
            if (next_word.done_res) finished_cmds++;
         end
         pending  <= predicted_ticks.size();
         bus_idle <= seg == SEG_IDLE;
      end
   end

endmodule

FILE: bench/tb_i2c_bit_level_master.sv
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;

   typedef logic [i2cbm_pkg::OPCODE_W-1:0] opcode_type;
   typedef logic [i2cbm_pkg::BYTE_W-1:0]   byte_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_command_valid;
   opcode_type                      req_opcode;
   byte_type                        req_write_byte;
   logic                            req_sda_sample;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_scl_level;
   logic                            rsp_sda_release;
   logic                            rsp_busy_res;
   logic                            rsp_done_res;
   byte_type                        rsp_read_byte;
   logic                            rsp_ack_seen;
   logic                            csr_write_enable;
   logic [i2cbm_pkg::CSR_IDX_W-1:0] csr_index;
   byte_type                        csr_write_data;

   int   failures;
   int   pending;
   logic bus_idle;
   int   checked_words;
   int   finished_cmds;
   int   ticks_sent;
   int   settings_used;
   bit   req_calm;

   i2c_bit_level_master uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command_valid (req_command_valid),
      .req_opcode        (req_opcode),
      .req_write_byte    (req_write_byte),
      .req_sda_sample    (req_sda_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scl_level     (rsp_scl_level),
      .rsp_sda_release   (rsp_sda_release),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_ack_seen      (rsp_ack_seen),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   i2cbm_bus_checker bus_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command_valid (req_command_valid),
      .req_opcode        (req_opcode),
      .req_write_byte    (req_write_byte),
      .req_sda_sample    (req_sda_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scl_level     (rsp_scl_level),
      .rsp_sda_release   (rsp_sda_release),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_ack_seen      (rsp_ack_seen),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .failures          (failures),
      .pending           (pending),
      .bus_idle          (bus_idle),
      .checked_words     (checked_words),
      .finished_cmds     (finished_cmds)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(2, 1);
      if (r < 98) return $urandom_range(6, 3);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic sda_level(input int low_pct);
      return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   function automatic opcode_type pick_opcode();
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         return opcode_type'($urandom_range({i2cbm_pkg::OPCODE_W{1'b1}},
                                            i2cbm_pkg::OP_READ_NACK + 1));
      end
      if (r < 24) return i2cbm_pkg::OP_START;
      if (r < 36) return i2cbm_pkg::OP_STOP;
      if (r < 66) return i2cbm_pkg::OP_WRITE;
      if (r < 83) return i2cbm_pkg::OP_READ_ACK;
      return i2cbm_pkg::OP_READ_NACK;
   endfunction

   task automatic send_tick(input logic cv, input opcode_type op,
                            input byte_type wb, input logic sda);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command_valid <= cv;
      req_opcode        <= op;
      req_write_byte    <= wb;
      req_sda_sample    <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // issue one command, then clock the bus until it goes idle again
   task automatic run_command(input opcode_type op, input byte_type wb,
                              input int low_pct, input bit offer_while_busy);
      send_tick(1'b1, op, wb, sda_level(low_pct));
      send_tick(offer_while_busy, pick_opcode(), 8'($urandom), sda_level(low_pct));
      while (!bus_idle) begin
         send_tick(1'b0, pick_opcode(), 8'($urandom), sda_level(low_pct));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic settle();
      send_tick(1'b0, i2cbm_pkg::OP_START, '0, 1'b1);
      send_tick(1'b0, i2cbm_pkg::OP_START, '0, 1'b1);
      while (!bus_idle) send_tick(1'b0, i2cbm_pkg::OP_START, '0, 1'b1);
      drain_results();
   endtask

   task automatic set_timing(input byte_type long_v, input byte_type short_v,
                             input byte_type limit_v);
      csr_write_enable <= 1'b1;
      csr_index        <= i2cbm_pkg::CSR_LONG_PHASE;
      csr_write_data   <= long_v;
      @(posedge clock);
      csr_index        <= i2cbm_pkg::CSR_SHORT_PHASE;
      csr_write_data   <= short_v;
      @(posedge clock);
      csr_index        <= i2cbm_pkg::CSR_ACK_LIMIT;
      csr_write_data   <= limit_v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_phase(input int n, input int low_pct, input int offer_pct);
      repeat (n) begin
         send_tick($urandom_range(99) < offer_pct, pick_opcode(), 8'($urandom),
                   sda_level(low_pct));
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         int  stall_left;
         int  calm_left;
         bit  rsp_calm;
         @(posedge clock);
         if (calm_left <= 0) begin
            rsp_calm  = $urandom_range(3) == 0;
            calm_left = $urandom_range(400, 100);
         end else begin
            calm_left--;
         end
         if (stall_left > 0) stall_left--;
         else if (!rsp_calm) stall_left = pick_gap();
         rsp_stall <= stall_left > 0;
      end
   end

   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_command_valid <= 1'b0;
      req_opcode        <= i2cbm_pkg::OP_START;
      req_write_byte    <= '0;
      req_sda_sample    <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= i2cbm_pkg::CSR_LONG_PHASE;
      csr_write_data    <= '0;
      ticks_sent        = 0;
      settings_used     = 0;
      req_calm          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing values
      run_command(i2cbm_pkg::OP_START, 8'h00, 0, 1'b1);
      run_command(i2cbm_pkg::OP_READ_NACK + 3'd1, 8'hFF, 50, 1'b0);
      run_command({i2cbm_pkg::OPCODE_W{1'b1}}, 8'h00, 50, 1'b0);
      run_command(i2cbm_pkg::OP_STOP, 8'h00, 0, 1'b1);

      // long phase past eight bits, no ack wait
      settle();
      set_timing(8'd130, 8'hFF, 8'h00);
      run_command(i2cbm_pkg::OP_STOP, 8'h00, 0, 1'b0);

      // zero delays, longest ack wait
      settle();
      set_timing(8'h00, 8'h00, 8'hFF);
      run_command(i2cbm_pkg::OP_START, 8'h00, 0, 1'b1);
      run_command(i2cbm_pkg::OP_WRITE, 8'h81, 0, 1'b0);
      run_command(i2cbm_pkg::OP_READ_NACK, 8'h00, 50, 1'b0);
      run_command(i2cbm_pkg::OP_READ_ACK, 8'h00, 50, 1'b1);
      run_command(i2cbm_pkg::OP_STOP, 8'h00, 0, 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         if (ph == 7) begin
            set_timing(byte_type'($urandom_range(12, 5)), byte_type'($urandom_range(12, 5)),
                       byte_type'($urandom_range(30, 0)));
         end else if (ph == 0) begin
            set_timing(byte_type'($urandom_range(4, 1)), byte_type'($urandom_range(4, 1)),
                       8'h00);
         end else begin
            set_timing(byte_type'($urandom_range(4, 1)), byte_type'($urandom_range(4, 1)),
                       byte_type'($urandom_range(12, 0)));
         end
         req_calm = (ph % 3) == 0;
         random_phase(80, (ph % 4) * 8 + 4, 40);
      end
      req_calm = 1'b0;

      drain_results();
      $display("covered %0d bus ticks over %0d timing settings, %0d commands completed",
               ticks_sent, settings_used + 1, finished_cmds);
      $display("checked %0d result words, including ack hits, timeouts and zero delays",
               checked_words);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
